@@ src/chfs_pkg.sv @@
// shared types, constants and arithmetic helpers for the hmm forward scorer
package chfs_pkg;

  localparam int MAX_STATES = 8;
  localparam int ALPHABET   = 4;
  localparam int MAX_DEPTH  = 3;
  localparam int FRAC_BITS  = 16;
  localparam int CORR_STEPS = 32;

  typedef logic signed [23:0] val_t;
  typedef logic signed [47:0] alpha_t;
  typedef logic signed [49:0] acc_t;
  typedef logic signed [50:0] wide_t;

  typedef enum logic [1:0] {
    OP_LOAD_START = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_LOAD_EMIT  = 2'd2,
    OP_SCORE      = 2'd3
  } op_t;

  localparam logic CFG_NUM_STATES   = 1'b0;
  localparam logic CFG_CONTEXT_DEPTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINAL,
    ST_FDRAIN
  } state_t;

  typedef struct packed {
    logic rotate;
    logic shift_next;
    logic clear;
  } cell_ctl_t;

  localparam alpha_t ALPHA_MAX = {1'b0, {47{1'b1}}};
  localparam alpha_t ALPHA_MIN = {1'b1, {47{1'b0}}};

  // round(ln(1 + exp(-idx/4)) * 2^16)
  function automatic logic [15:0] lse_corr(input logic [4:0] idx);
    logic [15:0] c;
    case (idx)
      5'd0:  c = 16'd45426;
      5'd1:  c = 16'd37745;
      5'd2:  c = 16'd31069;
      5'd3:  c = 16'd25354;
      5'd4:  c = 16'd20530;
      5'd5:  c = 16'd16510;
      5'd6:  c = 16'd13200;
      5'd7:  c = 16'd10500;
      5'd8:  c = 16'd8318;
      5'd9:  c = 16'd6567;
      5'd10: c = 16'd5170;
      5'd11: c = 16'd4061;
      5'd12: c = 16'd3184;
      5'd13: c = 16'd2493;
      5'd14: c = 16'd1950;
      5'd15: c = 16'd1523;
      5'd16: c = 16'd1189;
      5'd17: c = 16'd928;
      5'd18: c = 16'd724;
      5'd19: c = 16'd565;
      5'd20: c = 16'd440;
      5'd21: c = 16'd343;
      5'd22: c = 16'd267;
      5'd23: c = 16'd208;
      5'd24: c = 16'd162;
      5'd25: c = 16'd126;
      5'd26: c = 16'd98;
      5'd27: c = 16'd77;
      5'd28: c = 16'd60;
      5'd29: c = 16'd47;
      5'd30: c = 16'd36;
      default: c = 16'd28;
    endcase
    return c;
  endfunction

  function automatic acc_t lse(input acc_t a, input acc_t b);
    wide_t       df;
    logic [50:0] d;
    acc_t        m;
    df = wide_t'(a) - wide_t'(b);
    d  = df[50] ? 51'(-df) : 51'(df);
    m  = (df > 0) ? a : b;
    if (d[50:19] == '0) begin
      m = m + acc_t'({34'd0, lse_corr(d[18:14])});
    end
    return m;
  endfunction

  function automatic alpha_t clamp_alpha(input wide_t v);
    alpha_t r;
    if (v < wide_t'(ALPHA_MIN)) begin
      r = ALPHA_MIN;
    end else if (v > wide_t'(ALPHA_MAX)) begin
      r = ALPHA_MAX;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic clamp_low(input wide_t v);
    return v < wide_t'(ALPHA_MIN);
  endfunction

endpackage

@@ src/chfs_if.sv @@
// item and result channel interfaces of the hmm forward scorer
interface chfs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [2:0]        row_index;
  logic [7:0]        column_index;
  logic signed [23:0] log_value;
  logic [7:0]        symbol;
  logic              active;
  logic              last;
  modport source (output valid, operation, row_index, column_index, log_value, symbol,
                  active, last, input ready);
  modport sink (input valid, operation, row_index, column_index, log_value, symbol,
                active, last, output ready);
endinterface

interface chfs_out_if;
  logic              valid;
  logic              ready;
  logic signed [47:0] seq_score;
  logic [31:0]       sequence_length;
  logic              saturated;
  modport source (output valid, seq_score, sequence_length, saturated, input ready);
  modport sink (input valid, seq_score, sequence_length, saturated, output ready);
endinterface

@@ src/chfs_cell.sv @@
// one state cell: holds alpha and the pending next alpha of a hidden state
module chfs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  chfs_pkg::cell_ctl_t ctl,
  input  logic               commit_en,
  input  chfs_pkg::alpha_t   alpha_in,
  input  chfs_pkg::alpha_t   next_in,
  output chfs_pkg::alpha_t   alpha_out,
  output chfs_pkg::alpha_t   next_out
);
  import chfs_pkg::*;

  alpha_t alpha_r, alpha_nxt;
  alpha_t next_r, next_nxt;

  always_comb begin
    alpha_nxt = alpha_r;
    if (ctl.clear) begin
      alpha_nxt = '0;
    end else if (commit_en) begin
      alpha_nxt = next_r;
    end else if (ctl.rotate) begin
      alpha_nxt = alpha_in;
    end
  end

  always_comb begin
    next_nxt = ctl.shift_next ? next_in : next_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      next_r  <= '0;
    end else begin
      alpha_r <= alpha_nxt;
      next_r  <= next_nxt;
    end
  end

  assign alpha_out = alpha_r;
  assign next_out  = next_r;

endmodule

@@ src/context_hmm_forward_scorer.sv @@
// top level of the context hmm forward scorer
// A symbol item runs a scoring pass, a pipeline drain and a commit: one shared
// log-sum-exp unit visits every source and target state pair of the eight-cell alpha
// ring, one pair per cycle. A symbol marked last adds a final pass plus a drain to
// reduce the final alphas into the sequence score, and that reduction waits until the
// result register is free. Results are held in an output register, so the next item is
// taken while a result waits.
module context_hmm_forward_scorer (
  input  logic         clk,
  input  logic         rst_n,
  chfs_in_if.sink      in_if,
  chfs_out_if.source   out_if,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data
);
  import chfs_pkg::*;

  localparam int N = MAX_STATES;

  state_t state_r, state_nxt;

  logic [3:0] num_states_r;
  logic [1:0] cdepth_r;
  logic [3:0] k_use;

  val_t   start_r [N];
  val_t   trans_mem [N*N];
  val_t   emit_mem [N*256];
  val_t   trans_q;
  val_t   emit_q;

  logic [7:0]  hist_r [MAX_DEPTH];
  logic [31:0] count_r;
  logic        sat_r;
  logic [7:0]  col_e_r;
  logic        first_sym_r, act_r, symv_r, last_r;
  logic [5:0]  step_r;

  logic        issue, fin_issue, commit, seq_clear, accept, score_acc;
  cell_ctl_t   ctl;

  alpha_t alpha_o [N];
  alpha_t next_o [N];
  alpha_t head;
  alpha_t insert_val;

  // pipeline registers
  logic       p1_v, p1_fin, p1_first, p1_use, p1_lastf;
  logic [2:0] p1_j;
  alpha_t     p1_alpha;
  logic       p2_v, p2_fin, p2_first, p2_use, p2_lastf;
  logic [2:0] p2_j;
  acc_t       p2_sum;
  acc_t       acc_r;
  logic       p3_v, p3_fin;
  logic [2:0] p3_j;

  logic              out_valid_r;
  alpha_t            out_ll_r;
  logic [31:0]       out_len_r;
  logic              out_sat_r;

  logic [2:0] st_i, st_j;
  logic [7:0] h;
  logic       win_ok;
  acc_t       sum_c;
  wide_t      fin_v;
  alpha_t     ll_c;

  assign k_use = (num_states_r == 4'd0) ? 4'd1 :
                 (num_states_r > 4'(N)) ? 4'(N) : num_states_r;

  assign accept    = in_if.valid && in_if.ready;
  assign score_acc = accept && (in_if.operation == OP_SCORE);
  assign st_i = step_r[2:0];
  assign st_j = step_r[5:3];

  // state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (score_acc) state_nxt = ST_SCORE;
      ST_SCORE:  if (step_r == 6'd63) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (p3_v && !p3_fin && p3_j == 3'd7) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = last_r ? ST_FINAL : ST_IDLE;
      ST_FINAL:  if (!out_valid_r && st_i == 3'd7) state_nxt = ST_FDRAIN;
      ST_FDRAIN: if (p3_v && p3_fin) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fin_issue = (state_r == ST_FINAL) && !out_valid_r;
    issue     = (state_r == ST_SCORE) || fin_issue;
    commit    = (state_r == ST_COMMIT);
    seq_clear = (state_r == ST_FDRAIN) && p3_v && p3_fin;
    in_if.ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= 4'd1;
      cdepth_r     <= 2'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_STATES) begin
        num_states_r <= cfg_data;
      end else begin
        cdepth_r <= cfg_data[1:0];
      end
    end
  end

  // table loads
  always_ff @(posedge clk) begin
    if (accept && in_if.operation == OP_LOAD_START) begin
      start_r[in_if.row_index] <= in_if.log_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_if.operation == OP_LOAD_TRANS && in_if.column_index < 8'(N)) begin
      trans_mem[{in_if.row_index, in_if.column_index[2:0]}] <= in_if.log_value;
    end
    if (issue && !fin_issue) begin
      trans_q <= trans_mem[{st_i, st_j}];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_if.operation == OP_LOAD_EMIT) begin
      emit_mem[{in_if.row_index, in_if.column_index}] <= in_if.log_value;
    end
    if (issue && !fin_issue && st_i == 3'd7) begin
      emit_q <= emit_mem[{st_j, col_e_r}];
    end
  end

  // emission context
  always_comb begin
    win_ok = (cdepth_r != 2'd0) && (count_r >= 32'(cdepth_r));
    for (int d = 0; d < MAX_DEPTH; d++) begin
      if (d < int'(cdepth_r) && hist_r[d] >= 8'(ALPHABET)) begin
        win_ok = 1'b0;
      end
    end
    h = 8'd0;
    for (int d = MAX_DEPTH - 1; d >= 0; d--) begin
      if (d < int'(cdepth_r)) begin
        h = 8'(h * ALPHABET) + hist_r[d];
      end
    end
    if (!win_ok) begin
      h = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || seq_clear) begin
      count_r <= '0;
      for (int d = 0; d < MAX_DEPTH; d++) begin
        hist_r[d] <= '0;
      end
    end else if (score_acc) begin
      if (count_r != '1) begin
        count_r <= count_r + 32'd1;
      end
      hist_r[0] <= in_if.symbol;
      for (int d = 1; d < MAX_DEPTH; d++) begin
        hist_r[d] <= hist_r[d-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (score_acc) begin
      col_e_r     <= 8'(h * ALPHABET) + in_if.symbol;
      first_sym_r <= (count_r == '0);
      act_r       <= in_if.active;
      symv_r      <= (in_if.symbol < 8'(ALPHABET));
      last_r      <= in_if.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || score_acc) begin
      step_r <= '0;
    end else if (issue) begin
      step_r <= step_r + 6'd1;
    end
  end

  // cell ring
  assign head = alpha_o[0];
  assign ctl.rotate     = issue;
  assign ctl.shift_next = p3_v && !p3_fin;
  assign ctl.clear      = seq_clear;

  for (genvar c = 0; c < N; c++) begin : g_cell
    chfs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .commit_en (commit && (c < int'(k_use))),
      .alpha_in  (alpha_o[(c + 1) % N]),
      .next_in   ((c == N - 1) ? insert_val : next_o[(c + 1) % N]),
      .alpha_out (alpha_o[c]),
      .next_out  (next_o[c])
    );
  end

  // stage 1: capture head alpha
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= issue;
    end
    p1_fin   <= fin_issue;
    p1_j     <= st_j;
    p1_alpha <= head;
    p1_first <= (st_i == 3'd0);
    p1_lastf <= (st_i == 3'd7);
    p1_use   <= ({1'b0, st_i} < k_use) && (fin_issue || !first_sym_r || st_i == 3'd0);
  end

  // stage 2: path sum
  always_comb begin
    if (p1_fin) begin
      sum_c = acc_t'(p1_alpha);
    end else if (first_sym_r) begin
      sum_c = acc_t'(start_r[p1_j]);
    end else begin
      sum_c = acc_t'(p1_alpha) + acc_t'(trans_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
    p2_fin   <= p1_fin;
    p2_j     <= p1_j;
    p2_sum   <= sum_c;
    p2_first <= p1_first;
    p2_use   <= p1_use;
    p2_lastf <= p1_lastf;
  end

  // stage 3: log-sum-exp accumulate
  always_ff @(posedge clk) begin
    if (p2_v) begin
      if (p2_first) begin
        acc_r <= p2_sum;
      end else if (p2_use) begin
        acc_r <= lse(acc_r, p2_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v <= 1'b0;
    end else begin
      p3_v <= p2_v && p2_lastf;
    end
    p3_fin <= p2_fin;
    p3_j   <= p2_j;
  end

  // stage 4: emission add and clamp
  always_comb begin
    fin_v = wide_t'(acc_r);
    if (!p3_fin && act_r && symv_r) begin
      fin_v = wide_t'(acc_r) + wide_t'(emit_q);
    end
    ll_c       = clamp_alpha(wide_t'(acc_r));
    insert_val = clamp_alpha(fin_v);
  end

  // only states in use count toward the flag
  always_ff @(posedge clk) begin
    if (!rst_n || seq_clear) begin
      sat_r <= 1'b0;
    end else if (p3_v && !p3_fin && ({1'b0, p3_j} < k_use) && clamp_low(fin_v)) begin
      sat_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p3_v && p3_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (p3_v && p3_fin) begin
      out_ll_r  <= ll_c;
      out_len_r <= count_r;
      out_sat_r <= sat_r || clamp_low(wide_t'(acc_r));
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.seq_score       = out_ll_r;
  assign out_if.sequence_length = out_len_r;
  assign out_if.saturated       = out_sat_r;

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !p1_v && !p2_v && !p3_v)
    else $error("pipeline busy while idle");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    p3_v && p3_fin |=> out_valid_r)
    else $error("final reduction did not load result");

  a_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
    fin_issue |-> !out_valid_r)
    else $error("final reduction started with result pending");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_len_r != 32'd0)
    else $error("result with zero length");

endmodule
